[rtl/esc_pkg.sv]
// Shared types and constants of the elevator stop scheduler.
`default_nettype none

package esc_pkg;

   localparam int FLOOR_W        = 4;
   localparam int TYPE_W         = 2;
   localparam int NUM_FLOORS_DEF = 16;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_HALL = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_CAR  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RUN  = 2'd2;

   localparam logic DIR_UP   = 1'b0;
   localparam logic DIR_DOWN = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_SERVE,
      ST_REPOS,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;     // sort a hall/car request into a set
      logic merge;    // start of pass: fold waiting set into the far set
      logic serve;    // emit next stop of the current pass
      logic repos;    // optional reposition stop, then turn
      logic flush;    // release held stop as the final one
   } cmd_type;

   typedef struct packed {
      logic all_empty;
      logic serve_empty;
      logic stall;       // a new stop can not be taken this cycle
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

[rtl/esc_if.sv]
// Request and response channel interfaces of the elevator stop scheduler.
`default_nettype none

interface esc_req_if;
   logic                          valid;
   logic                          ready;
   logic [esc_pkg::TYPE_W-1:0]    req_type;
   logic [esc_pkg::FLOOR_W-1:0]   floor;
   logic                          dir;

   modport source (output valid, req_type, floor, dir, input ready);
   modport sink   (input valid, req_type, floor, dir, output ready);
endinterface

interface esc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [esc_pkg::FLOOR_W-1:0]   stop_floor;
   logic                          travel_dir;
   logic                          last;

   modport source (output valid, stop_floor, travel_dir, last, input ready);
   modport sink   (input valid, stop_floor, travel_dir, last, output ready);
endinterface

`default_nettype wire

[rtl/esc_ctrl.sv]
// Sequencing state machine of the elevator stop scheduler.
`default_nettype none

module esc_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire logic [esc_pkg::TYPE_W-1:0]  req_type,
   output logic                             req_ready,
   input  wire esc_pkg::stat_type           stat,
   output esc_pkg::cmd_type                 cmd
);

   esc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= esc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         esc_pkg::ST_IDLE: begin
            if (req_valid && req_type == esc_pkg::REQ_RUN) begin
               state_in = esc_pkg::ST_MERGE;
            end
         end
         esc_pkg::ST_MERGE: begin
            state_in = stat.all_empty ? esc_pkg::ST_FLUSH : esc_pkg::ST_SERVE;
         end
         esc_pkg::ST_SERVE: begin
            if (stat.serve_empty) begin
               state_in = esc_pkg::ST_REPOS;
            end
         end
         esc_pkg::ST_REPOS: begin
            if (!stat.stall) begin
               state_in = esc_pkg::ST_MERGE;
            end
         end
         esc_pkg::ST_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) begin
               state_in = esc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = esc_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         esc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid && req_type != esc_pkg::REQ_RUN;
         end
         esc_pkg::ST_MERGE: begin
            cmd.merge = !stat.all_empty;
         end
         esc_pkg::ST_SERVE: begin
            cmd.serve = !stat.serve_empty && !stat.stall;
         end
         esc_pkg::ST_REPOS: begin
            cmd.repos = !stat.stall;
         end
         esc_pkg::ST_FLUSH: begin
            cmd.flush = stat.pend_valid && stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/esc_datapath.sv]
// Floor bitmaps, car position, held stop and output register.
`default_nettype none

module esc_datapath #(
   parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire esc_pkg::cmd_type             cmd,
   output esc_pkg::stat_type                 stat,
   input  wire logic [esc_pkg::TYPE_W-1:0]   req_type,
   input  wire logic [esc_pkg::FLOOR_W-1:0]  req_floor,
   input  wire logic                         req_dir,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [esc_pkg::FLOOR_W-1:0]       rsp_stop_floor,
   output logic                              rsp_travel_dir,
   output logic                              rsp_last
);

   localparam int SET_W = NUM_FLOORS;
   localparam int IDX_W = $clog2(NUM_FLOORS);
   localparam int FW    = esc_pkg::FLOOR_W;
   localparam logic [FW:0] FLOOR_LIM = (FW + 1)'(NUM_FLOORS);

   function automatic logic [IDX_W-1:0] lowest_idx(input logic [SET_W-1:0] s);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = SET_W - 1; i >= 0; i--) begin
         if (s[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] highest_idx(input logic [SET_W-1:0] s);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = 0; i < SET_W; i++) begin
         if (s[i]) r = IDX_W'(i);
      end
      return r;
   endfunction

   logic [SET_W-1:0] up_ff, up_in, down_ff, down_in, wait_ff, wait_in;
   logic [FW-1:0]    car_ff, car_in;
   logic             going_down_ff, going_down_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [FW-1:0]    pend_floor_ff, pend_floor_in;
   logic             pend_dir_ff, pend_dir_in;
   logic             out_valid_ff, out_valid_in;
   logic [FW-1:0]    out_floor_ff, out_floor_in;
   logic             out_dir_ff, out_dir_in;
   logic             out_last_ff, out_last_in;

   logic [FW-1:0]    lo_up, hi_dn;
   logic [SET_W-1:0] req_bit;
   logic             req_ok;
   logic             emit;
   logic [FW-1:0]    emit_floor;
   logic             emit_dir;
   logic             out_free;

   // floors above 15 never get a bit, so the low four index bits suffice
   assign lo_up   = FW'(lowest_idx(up_ff));
   assign hi_dn   = FW'(highest_idx(down_ff));
   assign req_bit = SET_W'(1) << req_floor;
   assign req_ok  = ({1'b0, req_floor} < FLOOR_LIM) &&
                    (req_type == esc_pkg::REQ_HALL || req_type == esc_pkg::REQ_CAR);
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      up_in         = up_ff;
      down_in       = down_ff;
      wait_in       = wait_ff;
      going_down_in = going_down_ff;
      emit          = 1'b0;
      emit_floor    = '0;
      emit_dir      = esc_pkg::DIR_UP;

      if (cmd.load && req_ok) begin
         if (!going_down_ff) begin
            if (req_type == esc_pkg::REQ_HALL && req_dir == esc_pkg::DIR_DOWN) begin
               down_in = down_ff | req_bit;
            end else if (req_floor < car_ff) begin
               wait_in = wait_ff | req_bit;
            end else begin
               up_in = up_ff | req_bit;
            end
         end else begin
            if (req_type == esc_pkg::REQ_HALL && req_dir == esc_pkg::DIR_UP) begin
               up_in = up_ff | req_bit;
            end else if (req_floor > car_ff) begin
               wait_in = wait_ff | req_bit;
            end else begin
               down_in = down_ff | req_bit;
            end
         end
      end

      if (cmd.merge) begin
         wait_in = '0;
         if (!going_down_ff) begin
            down_in = down_ff | wait_ff;
         end else begin
            up_in = up_ff | wait_ff;
         end
      end

      if (cmd.serve) begin
         emit = 1'b1;
         if (!going_down_ff) begin
            emit_floor = lo_up;
            emit_dir   = esc_pkg::DIR_UP;
            up_in      = up_ff & ~(SET_W'(1) << lo_up);
         end else begin
            emit_floor = hi_dn;
            emit_dir   = esc_pkg::DIR_DOWN;
            down_in    = down_ff & ~(SET_W'(1) << hi_dn);
         end
      end

      if (cmd.repos) begin
         going_down_in = !going_down_ff;
         if (!going_down_ff) begin
            emit       = (down_ff != '0) && (car_ff < hi_dn);
            emit_floor = hi_dn;
            emit_dir   = esc_pkg::DIR_UP;
         end else begin
            emit       = (up_ff != '0) && (car_ff > lo_up);
            emit_floor = lo_up;
            emit_dir   = esc_pkg::DIR_DOWN;
         end
      end
   end

   // one stop is held back so the final one can be tagged
   always_comb begin
      car_in        = emit ? emit_floor : car_ff;
      pend_valid_in = pend_valid_ff;
      pend_floor_in = pend_floor_ff;
      pend_dir_in   = pend_dir_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_floor_in  = out_floor_ff;
      out_dir_in    = out_dir_ff;
      out_last_in   = out_last_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_floor_in = emit_floor;
         pend_dir_in   = emit_dir;
      end
      if ((emit && pend_valid_ff) || cmd.flush) begin
         out_valid_in = 1'b1;
         out_floor_in = pend_floor_ff;
         out_dir_in   = pend_dir_ff;
         out_last_in  = cmd.flush;
      end
      if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff         <= '0;
         down_ff       <= '0;
         wait_ff       <= '0;
         car_ff        <= '0;
         going_down_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         up_ff         <= up_in;
         down_ff       <= down_in;
         wait_ff       <= wait_in;
         car_ff        <= car_in;
         going_down_ff <= going_down_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_floor_ff <= pend_floor_in;
      pend_dir_ff   <= pend_dir_in;
      out_floor_ff  <= out_floor_in;
      out_dir_ff    <= out_dir_in;
      out_last_ff   <= out_last_in;
   end

   assign stat.all_empty   = (up_ff == '0) && (down_ff == '0) && (wait_ff == '0);
   assign stat.serve_empty = going_down_ff ? (down_ff == '0) : (up_ff == '0);
   assign stat.stall       = pend_valid_ff && !out_free;
   assign stat.pend_valid  = pend_valid_ff;
   assign stat.out_free    = out_free;

   assign rsp_valid      = out_valid_ff;
   assign rsp_stop_floor = out_floor_ff;
   assign rsp_travel_dir = out_dir_ff;
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

[rtl/elevator_stop_scheduler_core.sv]
// Top level of the elevator stop scheduler: controller plus datapath.
`default_nettype none

// Elevator stop scheduler, LOOK order over per-floor bitmaps. Hall words
// (floor, direction) and car words (floor) are sorted into an up, a down or
// a waiting set and give no response; a floor at or above NUM_FLOORS, and
// request code three, are dropped. A run word emits the car's stops until
// all sets are empty: each pass first folds the waiting set in, then serves
// its stops one by one until the pass set is empty (a priority encoder
// over the active bitmap picks the next floor), then makes the optional
// reposition stop and turns; a closing step finds all sets empty and a
// final step tags the last stop. A run has at most two passes. One stop
// is held back inside so the last flag can be set, and a second sits in
// the output register, so response back pressure stalls the run only when
// both are full. A run with nothing pending gives no response. New request
// words are taken only between runs.
module elevator_stop_scheduler_core #(
   parameter int NUM_FLOORS = esc_pkg::NUM_FLOORS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   esc_req_if.sink    req_chan,
   esc_rsp_if.source  rsp_chan
);

   esc_pkg::cmd_type  cmd;
   esc_pkg::stat_type stat;
   logic              req_ready;

   esc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   esc_datapath #(
      .NUM_FLOORS (NUM_FLOORS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_chan.req_type),
      .req_floor      (req_chan.floor),
      .req_dir        (req_chan.dir),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_stop_floor (rsp_chan.stop_floor),
      .rsp_travel_dir (rsp_chan.travel_dir),
      .rsp_last       (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

`ifndef SYNTHESIS
   // between runs no stop is left held back
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready |-> !stat.pend_valid)
      else $error("stop still held while taking a new word");

   // a run word closes the request side on the next cycle
   a_run_blocks: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_ready && req_chan.req_type == esc_pkg::REQ_RUN
      |=> !req_ready)
      else $error("request side open right after a run word");

   // a new stop is only produced when the held one can move out
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.serve || cmd.repos |-> !stat.stall)
      else $error("stop produced while output path is full");

   // final stop release needs a held stop and a free output register
   a_flush_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> stat.pend_valid && stat.out_free)
      else $error("bad final stop release");

   // a pass never starts with all sets empty
   a_merge_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.merge |-> !stat.all_empty)
      else $error("pass started with nothing pending");
`endif

endmodule

`default_nettype wire

[sim/esc_tb_pkg.sv]
// Stop-word scoreboard of the elevator stop scheduler bench: predicts and checks stops.
`default_nettype none

package esc_tb_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import esc_pkg::*;

   localparam int FLOORS = NUM_FLOORS_DEF;

   // request code three has no function in the block and must be dropped
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      logic [FLOOR_W-1:0] floor;
      logic               travel_dir;
      logic               last;
   } stop_word_type;

   class stop_scoreboard;
      logic [FLOOR_W-1:0] car_floor;
      logic               car_dir;
      logic [FLOORS-1:0]  up_set;
      logic [FLOORS-1:0]  down_set;
      logic [FLOORS-1:0]  waiting_set;
      stop_word_type      expected_stops[$];
      int                 mismatch_count;

      function new();
         car_floor      = '0;
         car_dir        = DIR_UP;
         up_set         = '0;
         down_set       = '0;
         waiting_set    = '0;
         mismatch_count = 0;
      endfunction

      function int lowest_floor(logic [FLOORS-1:0] floors);
         for (int i = 0; i < FLOORS; i++)
            if (floors[i]) return i;
         return 0;
      endfunction

      function int highest_floor(logic [FLOORS-1:0] floors);
         for (int i = FLOORS - 1; i >= 0; i--)
            if (floors[i]) return i;
         return 0;
      endfunction

      // every stop moves the car, repositioning stops included
      function void add_stop(int fl, logic dir);
         stop_word_type w;
         w.floor      = fl[FLOOR_W-1:0];
         w.travel_dir = dir;
         w.last       = 1'b0;
         expected_stops.push_back(w);
         car_floor = w.floor;
      endfunction

      function void run_all_stops();
         int fl;
         int first;
         first = expected_stops.size();
         while (up_set != '0 || down_set != '0 || waiting_set != '0) begin
            if (car_dir == DIR_UP) begin
               down_set    = down_set | waiting_set;
               waiting_set = '0;
               while (up_set != '0) begin
                  fl = lowest_floor(up_set);
                  add_stop(fl, DIR_UP);
                  up_set[fl] = 1'b0;
               end
               if (down_set != '0) begin
                  fl = highest_floor(down_set);
                  if (int'(car_floor) < fl) add_stop(fl, DIR_UP);
               end
               car_dir = DIR_DOWN;
            end else begin
               up_set      = up_set | waiting_set;
               waiting_set = '0;
               while (down_set != '0) begin
                  fl = highest_floor(down_set);
                  add_stop(fl, DIR_DOWN);
                  down_set[fl] = 1'b0;
               end
               if (up_set != '0) begin
                  fl = lowest_floor(up_set);
                  if (int'(car_floor) > fl) add_stop(fl, DIR_DOWN);
               end
               car_dir = DIR_UP;
            end
         end
         if (expected_stops.size() > first)
            expected_stops[expected_stops.size() - 1].last = 1'b1;
      endfunction

      function void note_request(logic [TYPE_W-1:0] kind, logic [FLOOR_W-1:0] fl, logic dir);
         if (kind == REQ_RUN) begin
            run_all_stops();
         end else if ((kind == REQ_HALL || kind == REQ_CAR) && int'(fl) < FLOORS) begin
            if (car_dir == DIR_UP) begin
               if (kind == REQ_HALL && dir == DIR_DOWN) down_set[fl] = 1'b1;
               else if (fl < car_floor)                 waiting_set[fl] = 1'b1;
               else                                     up_set[fl] = 1'b1;
            end else begin
               if (kind == REQ_HALL && dir == DIR_UP) up_set[fl] = 1'b1;
               else if (fl > car_floor)               waiting_set[fl] = 1'b1;
               else                                   down_set[fl] = 1'b1;
            end
         end
      endfunction

      function void report(string field, logic [FLOOR_W-1:0] want, logic [FLOOR_W-1:0] got);
         mismatch_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      endfunction

      function void check_stop(logic [FLOOR_W-1:0] fl, logic dir, logic last);
         stop_word_type w;
         if (expected_stops.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: stop word expected none, got floor %0d dir %0d last %0d",
                     $time, fl, dir, last);
            return;
         end
         w = expected_stops.pop_front();
         if (w.floor !== fl)        report("stop_floor", w.floor, fl);
         if (w.travel_dir !== dir)  report("travel_dir", w.travel_dir, dir);
         if (w.last !== last)       report("last", w.last, last);
      endfunction

      function int pending();
         return expected_stops.size();
      endfunction
   endclass

endpackage

`default_nettype wire

[sim/tb_top.sv]
// Top of the elevator stop scheduler bench: clock, reset, drivers, monitors and watchdog.
`default_nettype none

// Request words (hall, car, run and the unused code) go in through req_chan;
// stop words come back on rsp_chan. Every accepted request word is handed to
// the scoreboard, which keeps its own car state and up/down/waiting bitmaps
// and queues the stops a run must produce. Every accepted stop word is
// compared with the oldest queued stop, field by field.
//
// Stimulus: a short directed list first (floor extremes, both hall
// directions, waiting-set sorting in both car directions, a stop at the
// car's own floor, a reposition stop served again, an empty run, the unused
// code), then random traffic made mostly of request batches closed by a
// run, with noise, repeated runs and duplicate floors mixed in.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import esc_pkg::*;
   import esc_tb_pkg::*;

   localparam int WORD_TARGET     = 470;
   localparam int IDLE_LIMIT      = 4000;   // cycles with no word moving on either side
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int DRAIN_CYCLES    = 60;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   esc_req_if req_chan();
   esc_rsp_if rsp_chan();

   elevator_stop_scheduler_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   stop_scoreboard stop_sb;

   int          burst_left    = 0;
   int          words_sent    = 0;   // unused-code words do not count
   int          hold_requests = 0;   // bumped by the stimulus
   int          holds_started = 0;   // kept by the receiver
   int          hold_left     = 0;
   int          phase_left    = 0;
   rx_mode_type rx_mode       = RX_OPEN;
   int          idle_cycles   = 0;

   always #5 clock = ~clock;

   // Both monitors sample at the edge; all drivers use nonblocking updates,
   // so the values seen here are the ones the block saw.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         stop_sb.note_request(req_chan.req_type, req_chan.floor, req_chan.dir);
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         stop_sb.check_stop(rsp_chan.stop_floor, rsp_chan.travel_dir, rsp_chan.last);
   end

   // Receiver: phases of random length, each with its own ready pattern.
   // A hold-off request from the stimulus drops ready for a long stretch so
   // the run backs up into the block and the request side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (holds_started != hold_requests) begin
         holds_started++;
         hold_left = HOLD_OFF_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (phase_left == 0) begin
            rx_mode    = rx_mode_type'($urandom_range(0, 3));
            phase_left = $urandom_range(4, 80);
         end
         phase_left--;
         case (rx_mode)
            RX_OPEN:   rsp_chan.ready <= 1'b1;
            RX_COIN:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 5) == 0);
            default:   rsp_chan.ready <= (phase_left % 3 != 0);
         endcase
      end
   end

   // Watchdog: a hang shows up as a long stretch with no word accepted.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one word and returns at the edge that takes it. Between bursts
   // valid drops with junk on the payload.
   task automatic send_word(input logic [TYPE_W-1:0] kind, input logic [FLOOR_W-1:0] fl,
                            input logic dir);
      if (burst_left == 0) begin
         req_chan.valid    <= 1'b0;
         req_chan.req_type <= TYPE_W'($urandom_range(0, 3));
         req_chan.floor    <= FLOOR_W'($urandom_range(0, FLOORS - 1));
         req_chan.dir      <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      burst_left--;
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.floor    <= fl;
      req_chan.dir      <= dir;
      do @(posedge clock); while (!req_chan.ready);
      if (kind != REQ_UNUSED) words_sent++;
   endtask

   task automatic send_request();
      send_word($urandom_range(0, 1) ? REQ_CAR : REQ_HALL,
                FLOOR_W'($urandom_range(0, FLOORS - 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic send_run();
      send_word(REQ_RUN, FLOOR_W'($urandom_range(0, FLOORS - 1)), 1'($urandom_range(0, 1)));
   endtask

   // Sender sits idle until every queued stop has come back. The first edge
   // lets the monitor note the word accepted at the edge we returned on.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (stop_sb.pending() != 0) @(posedge clock);
   endtask

   // Long receiver hold-off: a full-house run plus more requests behind it,
   // sent back to back so they pile up while nothing drains.
   task automatic fill_while_held();
      hold_requests++;
      burst_left = 64;
      for (int i = 0; i < FLOORS; i++)
         send_word(REQ_CAR, FLOOR_W'(i), 1'($urandom_range(0, 1)));
      for (int i = 0; i < FLOORS; i += 3)
         send_word(REQ_HALL, FLOOR_W'(i), DIR_DOWN);
      send_run();
      repeat (8) send_request();
   endtask

   initial begin
      int                 pick;
      int                 n;
      logic [FLOOR_W-1:0] fl;
      bit                 held_done;
      bit                 paused;

      held_done = 1'b0;
      paused    = 1'b0;
      stop_sb   = new();

      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_HALL;
      req_chan.floor    <= '0;
      req_chan.dir      <= DIR_UP;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // car at floor 0 going up: plain up pass, then a down pass
      send_word(REQ_HALL, 4'd0, DIR_UP);
      send_word(REQ_CAR, 4'd15, DIR_DOWN);
      send_word(REQ_HALL, 4'd7, DIR_DOWN);
      send_word(REQ_RUN, 4'd0, DIR_UP);
      // nothing pending: no stop words
      send_word(REQ_RUN, 4'd15, DIR_DOWN);
      // own-floor stop, up call below the car goes waiting, reposition to 12
      // and serve it again on the way down; the unused code must not count
      send_word(REQ_CAR, 4'd7, DIR_UP);
      send_word(REQ_HALL, 4'd3, DIR_UP);
      send_word(REQ_HALL, 4'd12, DIR_DOWN);
      send_word(REQ_UNUSED, 4'd5, DIR_DOWN);
      send_word(REQ_RUN, 4'd0, DIR_UP);
      // single up pass leaves the car going down at 9
      send_word(REQ_CAR, 4'd9, DIR_UP);
      send_word(REQ_RUN, 4'd9, DIR_UP);
      // sorting while going down
      send_word(REQ_HALL, 4'd14, DIR_UP);
      send_word(REQ_HALL, 4'd2, DIR_DOWN);
      send_word(REQ_CAR, 4'd13, DIR_DOWN);
      send_word(REQ_HALL, 4'd15, DIR_DOWN);
      send_word(REQ_CAR, 4'd0, DIR_UP);
      send_word(REQ_RUN, 4'd3, DIR_DOWN);
      send_word(REQ_HALL, 4'd0, DIR_DOWN);
      send_word(REQ_HALL, 4'd15, DIR_UP);
      send_word(REQ_CAR, 4'd15, DIR_UP);
      send_word(REQ_UNUSED, 4'd15, DIR_DOWN);
      send_word(REQ_RUN, 4'd15, DIR_DOWN);
      send_word(REQ_RUN, 4'd0, DIR_UP);
      wait_drained();

      while (words_sent < WORD_TARGET) begin
         if (!held_done && words_sent >= 160) begin
            fill_while_held();
            held_done = 1'b1;
         end else if (!paused && words_sent >= 320) begin
            wait_drained();
            paused = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               // batch of requests closed by a run; now and then a big one
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
               repeat (n) send_request();
               send_run();
            end else if (pick < 78) begin
               // noise, any code
               repeat ($urandom_range(1, 4))
                  send_word(TYPE_W'($urandom_range(0, 3)),
                            FLOOR_W'($urandom_range(0, FLOORS - 1)), 1'($urandom_range(0, 1)));
            end else if (pick < 86) begin
               // second run finds every set empty
               send_run();
               send_run();
            end else if (pick < 94) begin
               // duplicates on one floor merge into a single stop per set they land in
               fl = FLOOR_W'($urandom_range(0, FLOORS - 1));
               repeat ($urandom_range(2, 5))
                  send_word($urandom_range(0, 1) ? REQ_CAR : REQ_HALL, fl,
                            1'($urandom_range(0, 1)));
               send_run();
            end else if (pick < 97) begin
               wait_drained();
            end else begin
               // broken batch: requests with no run, picked up by a later one
               repeat ($urandom_range(1, 3)) send_request();
            end
         end
      end
      send_run();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (stop_sb.mismatch_count == 0 && stop_sb.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
